// ===== design/dsuf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsuf_pkg
// Shared widths, opcodes and controller/datapath interface structs for the
// disjoint-set union-find unit.
// ----------------------------------------------------------------------------
package dsuf_pkg;

    localparam int NODE_W = 11;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
    localparam logic [OP_W-1:0] OP_SIZE  = 2'd1;
    localparam logic [OP_W-1:0] OP_UNITE = 2'd2;

    // register index of element_count
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;   // write identity/one at sweep pointer
        logic load_item;    // capture input transaction
        logic par_rd_q;     // parent read address from last parent data
        logic halve;        // parent[node] <= grandparent, node <= grandparent
        logic save_r1;      // keep first root, start walk from node_b
        logic size_rd_r1;   // size read address from first root
        logic res_plain;    // result = node and its size
        logic save_s1;      // keep size of first root
        logic join_sizes;   // pick larger root, write summed size
        logic link;         // hang smaller root, clear its size, count merge
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_bad;
        logic is_root;
        logic is_unite;
        logic roots_equal;
        logic clear_done;
    } dp_status_t;

endpackage

// ===== design/dsuf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsuf_datapath
// Parent and size memories, walk registers, merge counter and result staging.
// ----------------------------------------------------------------------------
module dsuf_datapath #(
    parameter int MAX_NODES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsuf_pkg::dp_cmd_t             cmd,
    output dsuf_pkg::dp_status_t          status,
    input  logic                          cfg_we,
    input  logic [dsuf_pkg::NODE_W-1:0]   cfg_value,
    input  logic [dsuf_pkg::OP_W-1:0]     in_opcode,
    input  logic [dsuf_pkg::NODE_W-1:0]   in_node_a,
    input  logic [dsuf_pkg::NODE_W-1:0]   in_node_b,
    output logic [dsuf_pkg::NODE_W-1:0]   elem_count,
    output logic [dsuf_pkg::NODE_W-1:0]   res_root,
    output logic [dsuf_pkg::NODE_W-1:0]   res_size,
    output logic [dsuf_pkg::NODE_W-1:0]   res_components,
    output logic                          res_merged,
    output logic                          res_bad
);
    import dsuf_pkg::*;

    localparam int DEPTH = MAX_NODES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [NODE_W-1:0] RESET_COUNT =
        (1024 > MAX_NODES) ? NODE_W'(MAX_NODES) : NODE_W'(1024);

    logic [NODE_W-1:0] parent_mem [DEPTH];
    logic [NODE_W-1:0] size_mem   [DEPTH];

    logic [NODE_W-1:0] elem_count_reg, merge_count_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [OP_W-1:0]   op_reg;
    logic [NODE_W-1:0] b_reg, node_reg, r1_reg, s1_reg, big_reg, small_reg;
    logic [NODE_W-1:0] par_q_reg, size_q_reg;
    logic [NODE_W-1:0] res_root_reg, res_size_reg;
    logic              res_merged_reg, res_bad_reg;

    logic              a_ok, b_ok, item_bad;
    logic              r1_big;
    logic [NODE_W-1:0] big, small_root, sum;
    logic [NODE_W-1:0] cfg_clamped;

    logic              par_we, size_we;
    logic [AW-1:0]     par_waddr, par_raddr, size_waddr, size_raddr;
    logic [NODE_W-1:0] par_wdata, size_wdata;

    assign a_ok     = (in_node_a != '0) && (in_node_a <= elem_count_reg);
    assign b_ok     = (in_node_b != '0) && (in_node_b <= elem_count_reg);
    assign item_bad = !a_ok || ((in_opcode == OP_UNITE) && !b_ok);

    // union by size; a tie hangs the first root under the second
    assign r1_big     = s1_reg > size_q_reg;
    assign big        = r1_big ? r1_reg : node_reg;
    assign small_root = r1_big ? node_reg : r1_reg;
    assign sum        = s1_reg + size_q_reg;

    always_comb
    begin
        if (cfg_value == '0)
            cfg_clamped = NODE_W'(1);
        else if (32'(cfg_value) > 32'(MAX_NODES))
            cfg_clamped = NODE_W'(MAX_NODES);
        else
            cfg_clamped = cfg_value;
    end

    always_comb
    begin
        par_we    = 1'b0;
        par_waddr = AW'(node_reg);
        par_wdata = par_q_reg;
        priority if (cmd.clear_step)
        begin
            par_we    = 1'b1;
            par_waddr = clr_cnt_reg;
            par_wdata = NODE_W'(clr_cnt_reg);
        end
        else if (cmd.halve)
        begin
            par_we = 1'b1;
        end
        else if (cmd.link)
        begin
            par_we    = 1'b1;
            par_waddr = AW'(small_reg);
            par_wdata = big_reg;
        end
        else
        begin
            par_we = 1'b0;
        end
    end

    always_comb
    begin
        size_we    = 1'b0;
        size_waddr = clr_cnt_reg;
        size_wdata = NODE_W'(1);
        priority if (cmd.clear_step)
        begin
            size_we = 1'b1;
        end
        else if (cmd.join_sizes)
        begin
            size_we    = 1'b1;
            size_waddr = AW'(big);
            size_wdata = sum;
        end
        else if (cmd.link)
        begin
            size_we    = 1'b1;
            size_waddr = AW'(small_reg);
            size_wdata = '0;
        end
        else
        begin
            size_we = 1'b0;
        end
    end

    assign par_raddr  = cmd.par_rd_q ? AW'(par_q_reg) : AW'(node_reg);
    assign size_raddr = cmd.size_rd_r1 ? AW'(r1_reg) : AW'(node_reg);

    always_ff @(posedge clk)
    begin
        if (par_we)
            parent_mem[par_waddr] <= par_wdata;
        par_q_reg <= parent_mem[par_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_waddr] <= size_wdata;
        size_q_reg <= size_mem[size_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg  <= RESET_COUNT;
            merge_count_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else if (cfg_we)
        begin
            elem_count_reg  <= cfg_clamped;
            merge_count_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.link)
                merge_count_reg <= merge_count_reg + NODE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg         <= in_opcode;
            b_reg          <= in_node_b;
            node_reg       <= in_node_a;
            res_root_reg   <= '0;
            res_size_reg   <= '0;
            res_merged_reg <= 1'b0;
            res_bad_reg    <= item_bad;
        end
        if (cmd.save_r1)
        begin
            r1_reg   <= node_reg;
            node_reg <= b_reg;
        end
        if (cmd.halve)
            node_reg <= par_q_reg;
        if (cmd.res_plain)
        begin
            res_root_reg <= node_reg;
            res_size_reg <= size_q_reg;
        end
        if (cmd.save_s1)
            s1_reg <= size_q_reg;
        if (cmd.join_sizes)
        begin
            big_reg        <= big;
            small_reg      <= small_root;
            res_root_reg   <= big;
            res_size_reg   <= sum;
            res_merged_reg <= 1'b1;
        end
    end

    assign status.item_bad    = item_bad;
    assign status.is_root     = (par_q_reg == node_reg);
    assign status.is_unite    = (op_reg == OP_UNITE);
    assign status.roots_equal = (r1_reg == node_reg);
    assign status.clear_done  = (clr_cnt_reg == AW'(MAX_NODES));

    assign elem_count     = elem_count_reg;
    assign res_root       = res_root_reg;
    assign res_size       = res_size_reg;
    assign res_components = elem_count_reg - merge_count_reg;
    assign res_merged     = res_merged_reg;
    assign res_bad        = res_bad_reg;

endmodule

// ===== design/dsuf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsuf_ctrl
// Sequencer: table sweep, root walks with halving, size lookup and unite.
// ----------------------------------------------------------------------------
module dsuf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cfg_we,
    input  logic                 out_free,
    output logic                 out_push,
    input  dsuf_pkg::dp_status_t status,
    output dsuf_pkg::dp_cmd_t    cmd
);
    import dsuf_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_P, ST_CK_P, ST_CK_GP,
        ST_SZ, ST_U1, ST_U2, ST_U3, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   phase_b_reg, phase_b_next;

    always_comb
    begin
        state_next   = state_reg;
        phase_b_next = phase_b_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        out_push     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    phase_b_next  = 1'b0;
                    state_next    = status.item_bad ? ST_DONE : ST_RD_P;
                end
            end
            ST_RD_P:
            begin
                state_next = ST_CK_P;
            end
            ST_CK_P:
            begin
                cmd.par_rd_q = 1'b1;
                if (status.is_root)
                begin
                    if (status.is_unite && !phase_b_reg)
                    begin
                        cmd.save_r1  = 1'b1;
                        phase_b_next = 1'b1;
                        state_next   = ST_RD_P;
                    end
                    else if (status.is_unite && !status.roots_equal)
                    begin
                        cmd.size_rd_r1 = 1'b1;
                        state_next     = ST_U1;
                    end
                    else
                    begin
                        state_next = ST_SZ;
                    end
                end
                else
                begin
                    state_next = ST_CK_GP;
                end
            end
            ST_CK_GP:
            begin
                cmd.halve    = 1'b1;
                cmd.par_rd_q = 1'b1;
                state_next   = ST_CK_P;
            end
            ST_SZ:
            begin
                cmd.res_plain = 1'b1;
                state_next    = ST_DONE;
            end
            ST_U1:
            begin
                cmd.save_s1 = 1'b1;
                state_next  = ST_U2;
            end
            ST_U2:
            begin
                cmd.join_sizes = 1'b1;
                state_next     = ST_U3;
            end
            ST_U3:
            begin
                cmd.link   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_we)
            state_next = ST_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            phase_b_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_b_reg <= phase_b_next;
        end
    end

endmodule

// ===== design/disjoint_set_union_find_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disjoint_set_union_find_unit
// Union-find engine with path halving and union by size over nodes
// 1..element_count, streaming request/result and APB configuration.
// ----------------------------------------------------------------------------
// One request at a time. A find or size request whose node is already a root
// passes through accept, parent read, root check, size pickup and hand over.
// A unite whose two nodes are both roots does two parent reads and root
// checks, then the size compare, size update and link, and the hand over;
// when both nodes share a root the size pickup and hand over follow instead.
// Every halving step of a root walk adds one registered read of the parent
// memory per link. Out-of-range nodes go straight to the hand over. After
// reset and after every element_count write the tables are swept, one entry
// per cycle, over entries 0 to MAX_NODES, during which s_tready stays low.
// The result register lets the next request enter while a result still
// waits for m_tready.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_unit #(
    parameter int MAX_NODES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // node_a[10:0], node_b[21:11], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // root[10:0], set_size[21:11],
                                   // components[32:22], zero pad
    output logic [1:0]  m_tuser    // merged[0], bad_node[1]
);
    import dsuf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic              cfg_we, out_free, out_push;
    logic [NODE_W-1:0] elem_count, res_root, res_size, res_components;
    logic              res_merged, res_bad;

    logic              m_tvalid_reg;
    logic [NODE_W-1:0] out_root_reg, out_size_reg, out_comp_reg;
    logic              out_merged_reg, out_bad_reg;

    // register write in the APB access phase; one register, word aligned
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);
    assign prdata = {{(32 - NODE_W){1'b0}}, elem_count};

    dsuf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cfg_we   (cfg_we),
        .out_free (out_free),
        .out_push (out_push),
        .status   (status),
        .cmd      (cmd)
    );

    dsuf_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_value      (pwdata[NODE_W-1:0]),
        .in_opcode      (s_tuser),
        .in_node_a      (s_tdata[NODE_W-1:0]),
        .in_node_b      (s_tdata[2*NODE_W-1:NODE_W]),
        .elem_count     (elem_count),
        .res_root       (res_root),
        .res_size       (res_size),
        .res_components (res_components),
        .res_merged     (res_merged),
        .res_bad        (res_bad)
    );

    // result register: free when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_push)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_root_reg   <= res_root;
            out_size_reg   <= res_size;
            out_comp_reg   <= res_components;
            out_merged_reg <= res_merged;
            out_bad_reg    <= res_bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_comp_reg, out_size_reg, out_root_reg};
    assign m_tuser  = {out_bad_reg, out_merged_reg};

    // an accepted request keeps the port closed in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request port reopened right after accept");

    // a flagged result carries zero root and size and no merge
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[21:0] == 22'd0) && !m_tuser[0])
        else $error("bad-node result with nonzero payload");

    // a good result always names a real root
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[10:0] != 11'd0))
        else $error("good result with root zero");

endmodule
